// ----- rtl/wtpr_pkg.sv -----
// Shared types, constants and stage map of the w-term phase rotator.
package wtpr_pkg;

	// 2 * speed of light in m/s * 1e6: turns per (mm * 2f in mHz)
	localparam logic [49:0] PHASE_DEN = 50'd599584916000000;

	// radians per 2^-20 turn in units of 2^-24, scaled by 2^20
	localparam logic [26:0] PHASE_SCALE = 27'd105414357;

	localparam int HORNER_N = 28;
	localparam int DIV_N    = 21;
	localparam int CORDIC_N = 20;

	localparam logic signed [24:0] CORDIC_X0 = 25'sd2547003;

	localparam logic signed [26:0] ATAN_TAB [CORDIC_N] = '{
		27'sd13176795, 27'sd7778716, 27'sd4110060, 27'sd2086331, 27'sd1047214,
		27'sd524117,   27'sd262123,  27'sd131069,  27'sd65536,   27'sd32768,
		27'sd16384,    27'sd8192,    27'sd4096,    27'sd2048,    27'sd1024,
		27'sd512,      27'sd256,     27'sd128,     27'sd64,      27'sd32
	};

	// stage map
	localparam int S_W    = 1;
	localparam int S_ABS  = 2;
	localparam int S_F2   = 3;
	localparam int S_RED  = 4;
	localparam int S_HRN  = S_RED + 3;
	localparam int S_DIV  = S_HRN + HORNER_N;
	localparam int S_PH   = S_DIV + DIV_N;
	localparam int S_Z    = S_PH + 1;
	localparam int S_SC   = S_Z + CORDIC_N + 1;
	localparam int S_PRD  = S_SC + 1;
	localparam int S_OUT  = S_PRD + 1;
	localparam int LATENCY = S_OUT;

	typedef logic signed [23:0] vis_t;

	typedef struct packed {
		vis_t re_a;
		vis_t im_a;
		vis_t re_b;
		vis_t im_b;
		vis_t re_c;
		vis_t im_c;
		vis_t re_d;
		vis_t im_d;
		logic flag;
	} samp_t;

	typedef enum logic {
		REG_START_FREQ = 1'b0,
		REG_CHAN_WIDTH = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

endpackage

// ----- rtl/w_term_phase_rotator.sv -----
// w-term phase rotator: fully pipelined phase computation and visibility rotation.
//
// Usage:
//  - Config: write start_frequency (index 0) and channel_width (index 1), both in mHz,
//    through cfg_wr_en / cfg_index / cfg_data while no item is in flight.
//  - Input: an item is taken at each rising edge with start high and busy low. busy is
//    always low, so a new item may enter every cycle.
//  - Output: for each accepted item, done pulses for one cycle with the rotated,
//    saturated visibilities and the copied flag on the out_* ports.
//  - Throughput: one item per clock. Most stages hold one compare/subtract or one CORDIC
//    micro-rotation; the multiply stage holds one bank of multipliers.
//  - Pipeline: 2f = 2*start + width*(2ch+1), reduced mod D, then |w|*2f mod D by a 28-step
//    Horner chain of compare/subtract stages, a 21-stage restoring division for the turn
//    fraction, a 20-stage CORDIC for sin/cos, a multiply stage and a round/saturate stage.
//  - Reset clears the valid chain and both config registers; payload flops are not reset.
//  - The receiver cannot stall: every result is shown for exactly one cycle.
module w_term_phase_rotator
	import wtpr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_index,
	input  logic [38:0]        cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic signed [27:0] w_first,
	input  logic signed [27:0] w_second,
	input  logic [11:0]        channel,
	input  logic signed [23:0] re_a,
	input  logic signed [23:0] im_a,
	input  logic signed [23:0] re_b,
	input  logic signed [23:0] im_b,
	input  logic signed [23:0] re_c,
	input  logic signed [23:0] im_c,
	input  logic signed [23:0] re_d,
	input  logic signed [23:0] im_d,
	input  logic               flag_in,
	output logic               done,
	output logic signed [23:0] out_re_a,
	output logic signed [23:0] out_im_a,
	output logic signed [23:0] out_re_b,
	output logic signed [23:0] out_im_b,
	output logic signed [23:0] out_re_c,
	output logic signed [23:0] out_im_c,
	output logic signed [23:0] out_re_d,
	output logic signed [23:0] out_im_d,
	output logic               flag_out
);

	localparam int HRN_END = S_DIV - 1;
	localparam int DIV_END = S_PH - 1;

	logic [38:0] sf_q;
	logic [38:0] cw_q;
	logic        accept;
	logic [LATENCY:1] vld_s;

	samp_t              vis_s   [S_W:S_PRD];
	logic signed [28:0] w_s1;
	logic [12:0]        odd_s1;
	logic [27:0]        aw_s    [S_ABS:HRN_END-1];
	logic               wpos_s  [S_ABS:DIV_END];
	logic [51:0]        prod_s2;
	logic [52:0]        f2_s3;
	logic [52:0]        red_s   [S_RED:S_RED+2];
	logic [49:0]        rr_s    [S_HRN:HRN_END-1];
	logic [49:0]        hacc_s  [S_HRN:HRN_END];
	logic [49:0]        dacc_s  [S_DIV:DIV_END];
	logic [20:0]        dq_s    [S_DIV:DIV_END];
	logic [19:0]        ph_s;
	logic signed [24:0] cx_s    [S_Z:S_SC-1];
	logic signed [24:0] cy_s    [S_Z:S_SC-1];
	logic signed [26:0] cz_s    [S_Z:S_SC-1];
	quad_t              quad_s  [S_Z:S_SC-1];
	logic signed [18:0] cos_s, sin_s;
	logic signed [42:0] pr_s    [16];
	vis_t               out_s   [8];

	function automatic logic [49:0] horner_step(logic [49:0] acc, logic [49:0] r, logic b);
		logic [51:0] t;
		logic [51:0] d1;
		logic [51:0] d2;
		t  = {1'b0, acc, 1'b0} + (b ? {2'b0, r} : 52'd0);
		d1 = {2'b0, PHASE_DEN};
		d2 = {1'b0, PHASE_DEN, 1'b0};
		priority if (t >= d2) return 50'(t - d2);
		else if (t >= d1) return 50'(t - d1);
		else return 50'(t);
	endfunction

	function automatic logic signed [18:0] cs_round(logic signed [24:0] v);
		logic signed [25:0] t;
		t = ($signed({v[24], v}) + 26'sd16) >>> 5;
		priority if (t > 26'sd131071) return 19'sd131071;
		else if (t < -26'sd131072) return -19'sd131072;
		else return 19'(t);
	endfunction

	function automatic vis_t rot_sat(logic signed [42:0] a, logic signed [42:0] b);
		logic signed [44:0] t;
		t = (45'(a) - 45'(b) + 45'sd65536) >>> 17;
		priority if (t > 45'sd8388607) return 24'sd8388607;
		else if (t < -45'sd8388608) return -24'sd8388608;
		else return 24'(t);
	endfunction

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q <= '0;
			cw_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_START_FREQ: sf_q <= cfg_data;
				REG_CHAN_WIDTH: cw_q <= cfg_data;
			endcase
		end
	end

	// valid chain, one bit per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else vld_s <= {vld_s[LATENCY-1:1], accept};
	end

	// visibilities and flag ride along until the multiply stage
	always_ff @(posedge clk) begin
		vis_s[S_W] <= '{re_a: re_a, im_a: im_a, re_b: re_b, im_b: im_b,
			re_c: re_c, im_c: im_c, re_d: re_d, im_d: im_d, flag: flag_in};
		for (int i = S_W + 1; i <= S_PRD; i++) vis_s[i] <= vis_s[i-1];
	end

	// baseline w and odd channel multiplier 2*ch+1
	always_ff @(posedge clk) begin
		w_s1   <= {w_first[27], w_first} - {w_second[27], w_second};
		odd_s1 <= {channel, 1'b1};
	end

	// |w| and sign ride along
	always_ff @(posedge clk) begin
		aw_s[S_ABS] <= w_s1[28] ? 28'(-w_s1) : w_s1[27:0];
		for (int i = S_ABS + 1; i < HRN_END; i++) aw_s[i] <= aw_s[i-1];
	end

	always_ff @(posedge clk) begin
		wpos_s[S_ABS] <= ~w_s1[28];
		for (int i = S_ABS + 1; i <= DIV_END; i++) wpos_s[i] <= wpos_s[i-1];
	end

	// 2f = 2*start + width*(2ch+1), exact
	always_ff @(posedge clk) begin
		prod_s2 <= 52'(cw_q) * 52'(odd_s1);
		f2_s3   <= 53'({sf_q, 1'b0}) + 53'(prod_s2);
	end

	// 2f mod D: subtract 4D, 2D, D
	always_ff @(posedge clk) begin
		logic [52:0] d;
		logic [52:0] v;
		for (int g = 0; g < 3; g++) begin
			d = 53'(PHASE_DEN) << (2 - g);
			v = (g == 0) ? f2_s3 : red_s[S_RED+g-1];
			red_s[S_RED+g] <= (v >= d) ? v - d : v;
		end
	end

	// |w| * r mod D, one bit of |w| per stage, MSB first
	always_ff @(posedge clk) begin
		rr_s[S_HRN]   <= red_s[S_RED+2][49:0];
		hacc_s[S_HRN] <= horner_step('0, red_s[S_RED+2][49:0], aw_s[S_HRN-1][HORNER_N-1]);
		for (int k = 1; k < HORNER_N - 1; k++) rr_s[S_HRN+k] <= rr_s[S_HRN+k-1];
		for (int k = 1; k < HORNER_N; k++) begin
			hacc_s[S_HRN+k] <= horner_step(hacc_s[S_HRN+k-1], rr_s[S_HRN+k-1],
				aw_s[S_HRN+k-1][HORNER_N-1-k]);
		end
	end

	// m*2^21/D by restoring division, one quotient bit per stage
	always_ff @(posedge clk) begin
		logic [50:0] t;
		logic        ge;
		for (int j = 0; j < DIV_N; j++) begin
			t  = (j == 0) ? {hacc_s[HRN_END], 1'b0} : {dacc_s[S_DIV+j-1], 1'b0};
			ge = (t >= 51'(PHASE_DEN));
			dacc_s[S_DIV+j] <= ge ? 50'(t - 51'(PHASE_DEN)) : 50'(t);
			dq_s[S_DIV+j]   <= (j == 0) ? {20'd0, ge} : {dq_s[S_DIV+j-1][19:0], ge};
		end
	end

	// round to 20-bit turn fraction; negate for w >= 0
	always_ff @(posedge clk) begin
		logic [21:0] sum;
		sum = 22'(dq_s[DIV_END]) + 22'd1;
		ph_s <= wpos_s[DIV_END] ? 20'(20'd0 - sum[20:1]) : sum[20:1];
	end

	// angle to radians, then CORDIC rotation, one micro-rotation per stage
	always_ff @(posedge clk) begin
		logic [45:0]        zp;
		logic signed [24:0] dx;
		logic signed [24:0] dy;
		zp = 46'(ph_s[17:0]) * 46'(PHASE_SCALE) + 46'd524288;
		cx_s[S_Z]   <= CORDIC_X0;
		cy_s[S_Z]   <= '0;
		cz_s[S_Z]   <= {1'b0, zp[45:20]};
		quad_s[S_Z] <= quad_t'(ph_s[19:18]);
		for (int i = 0; i < CORDIC_N; i++) begin
			dx = cy_s[S_Z+i] >>> i;
			dy = cx_s[S_Z+i] >>> i;
			if (!cz_s[S_Z+i][26]) begin
				cx_s[S_Z+i+1] <= cx_s[S_Z+i] - dx;
				cy_s[S_Z+i+1] <= cy_s[S_Z+i] + dy;
				cz_s[S_Z+i+1] <= cz_s[S_Z+i] - ATAN_TAB[i];
			end else begin
				cx_s[S_Z+i+1] <= cx_s[S_Z+i] + dx;
				cy_s[S_Z+i+1] <= cy_s[S_Z+i] - dy;
				cz_s[S_Z+i+1] <= cz_s[S_Z+i] + ATAN_TAB[i];
			end
			quad_s[S_Z+i+1] <= quad_s[S_Z+i];
		end
	end

	// Q1.17 rounding, clamp and quadrant map
	always_ff @(posedge clk) begin
		logic signed [18:0] cc;
		logic signed [18:0] ss;
		cc = cs_round(cx_s[S_SC-1]);
		ss = cs_round(cy_s[S_SC-1]);
		unique case (quad_s[S_SC-1])
			QUAD_0: begin cos_s <= cc;  sin_s <= ss;  end
			QUAD_1: begin cos_s <= -ss; sin_s <= cc;  end
			QUAD_2: begin cos_s <= -cc; sin_s <= -ss; end
			QUAD_3: begin cos_s <= ss;  sin_s <= -cc; end
		endcase
	end

	// sixteen products: c*re, s*im, s*re, c*im per polarization
	always_ff @(posedge clk) begin
		vis_t re [4];
		vis_t im [4];
		re = '{vis_s[S_SC].re_a, vis_s[S_SC].re_b, vis_s[S_SC].re_c, vis_s[S_SC].re_d};
		im = '{vis_s[S_SC].im_a, vis_s[S_SC].im_b, vis_s[S_SC].im_c, vis_s[S_SC].im_d};
		for (int k = 0; k < 4; k++) begin
			pr_s[4*k]   <= 43'(cos_s) * 43'(re[k]);
			pr_s[4*k+1] <= 43'(sin_s) * 43'(im[k]);
			pr_s[4*k+2] <= 43'(sin_s) * 43'(re[k]);
			pr_s[4*k+3] <= 43'(cos_s) * 43'(im[k]);
		end
	end

	// sum, round half up from Q17, saturate
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			out_s[2*k]   <= rot_sat(pr_s[4*k], pr_s[4*k+1]);
			out_s[2*k+1] <= rot_sat(pr_s[4*k+2], -pr_s[4*k+3]);
		end
		flag_out <= vis_s[S_PRD].flag;
	end

	assign done     = vld_s[S_OUT];
	assign out_re_a = out_s[0];
	assign out_im_a = out_s[1];
	assign out_re_b = out_s[2];
	assign out_im_b = out_s[3];
	assign out_re_c = out_s[4];
	assign out_im_c = out_s[5];
	assign out_re_d = out_s[6];
	assign out_im_d = out_s[7];

endmodule

// ----- rtl/wtpr_checker.sv -----
// Port-level checker of the w-term phase rotator and its bind.
module wtpr_checker
	import wtpr_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               flag_in,
	input logic               flag_out,
	input logic signed [23:0] re_a,
	input logic signed [23:0] im_a,
	input logic signed [23:0] re_b,
	input logic signed [23:0] im_b,
	input logic signed [23:0] re_c,
	input logic signed [23:0] im_c,
	input logic signed [23:0] re_d,
	input logic signed [23:0] im_d,
	input logic signed [23:0] out_re_a,
	input logic signed [23:0] out_im_a,
	input logic signed [23:0] out_re_b,
	input logic signed [23:0] out_im_b,
	input logic signed [23:0] out_re_c,
	input logic signed [23:0] out_im_c,
	input logic signed [23:0] out_re_d,
	input logic signed [23:0] out_im_d
);

	logic [7:0] age_q;
	logic       warm;
	logic       zero_in;
	logic       zero_out;

	// cycles since reset release, saturating at the pipeline depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) age_q <= '0;
		else if (age_q != 8'(LATENCY)) age_q <= age_q + 8'd1;
	end

	assign warm     = (age_q == 8'(LATENCY));
	assign zero_in  = (re_a == 0) && (im_a == 0) && (re_b == 0) && (im_b == 0) &&
		(re_c == 0) && (im_c == 0) && (re_d == 0) && (im_d == 0);
	assign zero_out = (out_re_a == 0) && (out_im_a == 0) && (out_re_b == 0) &&
		(out_im_b == 0) && (out_re_c == 0) && (out_im_c == 0) && (out_re_d == 0) &&
		(out_im_d == 0);

	a_result_per_item: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (done == $past(start && !busy, LATENCY)))
		else $error("result strobe does not match item taken");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		!warm |-> !done)
		else $error("result before pipeline filled after reset");

	a_flag_copied: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done) |-> (flag_out == $past(flag_in, LATENCY)))
		else $error("flag not carried with its item");

	a_zero_stays_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done && $past(zero_in, LATENCY)) |-> zero_out)
		else $error("zero visibilities rotated to nonzero");

endmodule

bind w_term_phase_rotator wtpr_checker u_wtpr_checker (.*);
